// ===== sv/psgd_pkg.sv =====
package psgd_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int TIME_BITS_DEF  = 32;

  localparam int THR_W      = 16;
  localparam int SCALE_W    = 12;
  localparam int HOLD_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int DELTA_W    = SCALE_W + 1;

  localparam logic [THR_W-1:0]   ENTER_THR_RST = 16'd3277;
  localparam logic [THR_W-1:0]   EXIT_THR_RST  = 16'd4915;
  localparam logic [SCALE_W-1:0] SCALE_RST     = 12'd1500;
  localparam logic [HOLD_W-1:0]  HOLD_RST      = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTER_THR = 2'd0,
    REG_EXIT_THR  = 2'd1,
    REG_SCALE     = 2'd2,
    REG_HOLD      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [THR_W-1:0]   enter_thr;
    logic [THR_W-1:0]   exit_thr;
    logic [SCALE_W-1:0] scale;
    logic [HOLD_W-1:0]  hold;
  } cfg_t;

  typedef enum logic {
    PH_IDLE   = 1'b0,
    PH_ACTIVE = 1'b1
  } phase_t;

endpackage

// ===== sv/psgd_cfg.sv =====
module psgd_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [psgd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psgd_pkg::CFG_DATA_W-1:0]      cfg_data,
  output psgd_pkg::cfg_t                       cfg
);
  import psgd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ENTER_THR: cfg_nxt.enter_thr = cfg_data[THR_W-1:0];
        REG_EXIT_THR:  cfg_nxt.exit_thr  = cfg_data[THR_W-1:0];
        REG_SCALE:     cfg_nxt.scale     = cfg_data[SCALE_W-1:0];
        REG_HOLD:      cfg_nxt.hold      = cfg_data[HOLD_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enter_thr <= ENTER_THR_RST;
      cfg_r.exit_thr  <= EXIT_THR_RST;
      cfg_r.scale     <= SCALE_RST;
      cfg_r.hold      <= HOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/psgd_delta.sv =====
module psgd_delta #(
  parameter int SUM_W = psgd_pkg::COORD_BITS_DEF + 1
) (
  input  logic [SUM_W-1:0]                   a,
  input  logic [SUM_W-1:0]                   b,
  input  logic [psgd_pkg::SCALE_W-1:0]       scale,
  output logic signed [psgd_pkg::DELTA_W-1:0] delta
);
  import psgd_pkg::*;

  localparam int PROD_W = SUM_W + SCALE_W;

  logic              neg;
  logic [SUM_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [SCALE_W-1:0] units;
  logic [DELTA_W-1:0] pos;

  // (a - b) * scale >> SUM_W, truncated toward zero; fits in SCALE_W bits
  always_comb begin
    neg   = a < b;
    mag   = neg ? (b - a) : (a - b);
    prod  = PROD_W'(mag) * PROD_W'(scale);
    units = prod[SUM_W +: SCALE_W];
    pos   = {1'b0, units};
    delta = neg ? signed'(-pos) : signed'(pos);
  end

endmodule

// ===== sv/psgd_track.sv =====
module psgd_track #(
  parameter int COORD_BITS = psgd_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = psgd_pkg::TIME_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  psgd_pkg::cfg_t                        cfg,
  input  logic                                  adv,
  input  logic                                  out_ready,
  input  logic [COORD_BITS-1:0]                 ix,
  input  logic [COORD_BITS-1:0]                 iy,
  input  logic [COORD_BITS-1:0]                 mx,
  input  logic [COORD_BITS-1:0]                 my,
  input  logic [TIME_BITS-1:0]                  now,
  input  logic                                  lm_ok,
  output logic                                  out_valid,
  output logic signed [psgd_pkg::DELTA_W-1:0]   out_scroll_dx,
  output logic signed [psgd_pkg::DELTA_W-1:0]   out_scroll_dy,
  output logic                                  out_scroll_active
);
  import psgd_pkg::*;

  localparam int SUM_W = COORD_BITS + 1;
  localparam int CMP_W = (COORD_BITS > THR_W) ? COORD_BITS : THR_W;

  phase_t               phase_r, phase_nxt;
  logic [TIME_BITS-1:0] start_r, start_nxt;
  logic [SUM_W-1:0]     last_x_r, last_x_nxt;
  logic [SUM_W-1:0]     last_y_r, last_y_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic signed [DELTA_W-1:0] out_dx_r, out_dy_r;
  logic                 out_act_r;

  logic [SUM_W-1:0]      sx, sy;
  logic [COORD_BITS-1:0] gap;
  logic                  below_enter, above_exit, hold_done, emit, upd;
  logic [TIME_BITS-1:0]  elapsed;
  logic signed [DELTA_W-1:0] dx, dy;

  always_comb begin
    sx          = SUM_W'(ix) + SUM_W'(mx);
    sy          = SUM_W'(iy) + SUM_W'(my);
    gap         = (iy > my) ? (iy - my) : (my - iy);
    below_enter = CMP_W'(gap) < CMP_W'(cfg.enter_thr);
    above_exit  = CMP_W'(gap) > CMP_W'(cfg.exit_thr);
    elapsed     = now - start_r;
    hold_done   = elapsed >= TIME_BITS'(cfg.hold);
    upd         = adv && lm_ok;
  end

  psgd_delta #(.SUM_W(SUM_W)) u_dx (
    .a(sx), .b(last_x_r), .scale(cfg.scale), .delta(dx)
  );

  psgd_delta #(.SUM_W(SUM_W)) u_dy (
    .a(last_y_r), .b(sy), .scale(cfg.scale), .delta(dy)
  );

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (upd) begin
      unique case (phase_r)
        PH_IDLE:   if (below_enter) phase_nxt = PH_ACTIVE;
        PH_ACTIVE: if (above_exit)  phase_nxt = PH_IDLE;
        default:   phase_nxt = phase_r;
      endcase
    end
  end

  // tracking state and delta enable
  always_comb begin
    start_nxt  = start_r;
    last_x_nxt = last_x_r;
    last_y_nxt = last_y_r;
    emit       = 1'b0;
    if (upd) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (below_enter) begin
            start_nxt  = now;
            last_x_nxt = sx;
            last_y_nxt = sy;
          end
        end
        PH_ACTIVE: begin
          if (!above_exit) begin
            emit       = hold_done;
            last_x_nxt = sx;
            last_y_nxt = sy;
          end
        end
        default: emit = 1'b0;
      endcase
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      start_r   <= '0;
      last_x_r  <= '0;
      last_y_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      start_r   <= start_nxt;
      last_x_r  <= last_x_nxt;
      last_y_r  <= last_y_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_dx_r  <= emit ? dx : '0;
      out_dy_r  <= emit ? dy : '0;
      out_act_r <= lm_ok && (phase_nxt == PH_ACTIVE);
    end
  end

  assign out_valid         = out_vld_r;
  assign out_scroll_dx     = out_dx_r;
  assign out_scroll_dy     = out_dy_r;
  assign out_scroll_active = out_act_r;

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !lm_ok |=> out_dx_r == '0 && out_dy_r == '0 && !out_act_r)
    else $error("dropped frame gave nonzero result");

  a_delta_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_dx_r != '0 || out_dy_r != '0) |-> out_act_r)
    else $error("delta emitted while idle");

  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> phase_r == $past(phase_r))
    else $error("phase moved without an item");

  a_active_flag: assert property (@(posedge clk) disable iff (!rst_n)
    adv && lm_ok |=> out_act_r == (phase_r == PH_ACTIVE))
    else $error("active flag disagrees with phase");

endmodule

// ===== sv/pinch_scroll_gesture_detector_unit.sv =====
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_ready    | index_x/y, middle_x/y, time_ms, landmarks_complete
// out     | output    | out_valid / out_ready  | scroll_dx, scroll_dy, scroll_active
// cfg     | input     | cfg_we                 | cfg_index, cfg_data
//
// One item per cycle unless the output stalls; each item passes the input register, then the result register.
// The state update and scaling multipliers are combinational, between the input and result registers.
// Synchronous active-low reset clears the phase and tracking state and loads the config defaults.
// A stalled result holds the result register; the input register still fills,
// then in_ready drops until out_ready returns.
module pinch_scroll_gesture_detector_unit #(
  parameter int COORD_BITS = psgd_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = psgd_pkg::TIME_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [COORD_BITS-1:0]                 in_index_x,
  input  logic [COORD_BITS-1:0]                 in_index_y,
  input  logic [COORD_BITS-1:0]                 in_middle_x,
  input  logic [COORD_BITS-1:0]                 in_middle_y,
  input  logic [TIME_BITS-1:0]                  in_time_ms,
  input  logic                                  in_landmarks_complete,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [psgd_pkg::DELTA_W-1:0]   out_scroll_dx,
  output logic signed [psgd_pkg::DELTA_W-1:0]   out_scroll_dy,
  output logic                                  out_scroll_active,
  input  logic                                  cfg_we,
  input  logic [psgd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [psgd_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import psgd_pkg::*;

  cfg_t cfg;

  logic                  s1_vld_r, s1_vld_nxt;
  logic [COORD_BITS-1:0] ix_r, iy_r, mx_r, my_r;
  logic [TIME_BITS-1:0]  time_r;
  logic                  lm_r;
  logic                  adv, take;

  assign adv      = s1_vld_r && (!out_valid || out_ready);
  assign in_ready = !s1_vld_r || adv;
  assign take     = in_valid && in_ready;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (take) begin
      s1_vld_nxt = 1'b1;
    end else if (adv) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ix_r   <= in_index_x;
      iy_r   <= in_index_y;
      mx_r   <= in_middle_x;
      my_r   <= in_middle_y;
      time_r <= in_time_ms;
      lm_r   <= in_landmarks_complete;
    end
  end

  psgd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  psgd_track #(
    .COORD_BITS (COORD_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_track (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .adv               (adv),
    .out_ready         (out_ready),
    .ix                (ix_r),
    .iy                (iy_r),
    .mx                (mx_r),
    .my                (my_r),
    .now               (time_r),
    .lm_ok             (lm_r),
    .out_valid         (out_valid),
    .out_scroll_dx     (out_scroll_dx),
    .out_scroll_dy     (out_scroll_dy),
    .out_scroll_active (out_scroll_active)
  );

endmodule
